[hw/rtl/chme_pkg.sv]
// package: request/result types and sequencer states for the chained hash map engine
`default_nettype none
package chme_pkg;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_PUT    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [31:0] value_out;
    logic [1:0]  status;
    logic [8:0]  entry_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_READ,
    S_CMP,
    S_FREERD,
    S_FREEWAIT,
    S_ALLOC,
    S_UNLINK,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/chme_node_store.sv]
// node pool memory: key, value and link per node, one write port and one registered read
`default_nettype none
module chme_node_store #(
  parameter int NODES = 256,
  parameter int AW    = 8,
  parameter int LW    = 9
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [31:0]        rd_key,
  output logic [31:0]        rd_value,
  output logic [LW-1:0]      rd_link,
  input  wire logic          wr_node,
  input  wire logic          wr_link,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_key,
  input  wire logic [31:0]   wr_value,
  input  wire logic [LW-1:0] wr_link_data
);
  logic [31:0]   keys  [NODES];
  logic [31:0]   vals  [NODES];
  logic [LW-1:0] links [NODES];

  // key and value write with a full node; link writes alone too
  always_ff @(posedge clk) begin
    if (wr_node) begin
      keys[wr_addr] <= wr_key;
      vals[wr_addr] <= wr_value;
    end
    if (wr_node || wr_link) begin
      links[wr_addr] <= wr_link_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key   <= keys[rd_addr];
      rd_value <= vals[rd_addr];
      rd_link  <= links[rd_addr];
    end
  end
endmodule
`default_nettype wire

[hw/rtl/chained_hash_map_engine_top.sv]
// top level: request sequencer, bucket-head memory and free-list control of the hash map
//
//  channel | direction | payload         | handshake
//  req     | in        | chme_pkg::req_t | req_valid / req_stall
//  rsp     | out       | chme_pkg::rsp_t | rsp_valid / rsp_stall
//
// from acceptance to result: the head read, a read and a compare per chain node,
// a last read step on reaching the chain end, an allocation or unlink, then loading the result
// a put that reuses a freed node adds a read and a wait state for its free-list link
// after reset a clearing pass over all BUCKETS entries empties the bucket heads; no request is taken
// the result waits in an output register; a new request is taken no earlier than the
// cycle after it has gone
`default_nettype none
module chained_hash_map_engine_top #(
  parameter int BUCKETS = 64,
  parameter int NODES   = 256
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire chme_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output chme_pkg::rsp_t      rsp
);
  import chme_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW = $clog2(NODES + 1);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [LW-1:0] NIL = LW'(NODES);

  state_t state, state_next;

  // request registers
  op_t         op;
  logic [31:0] key, val;
  logic [BW-1:0] bkt;
  // walk registers
  logic [LW-1:0] cur, pred, hit_link, free_head, fresh_index;
  logic [8:0]    stored_count;
  logic [BW:0]   clr_idx;
  logic [31:0]   hit_val;
  logic          found;

  // bucket heads memory
  logic [LW-1:0] heads [BUCKETS];
  logic [LW-1:0] head_rd;
  logic          head_we;
  logic [BW-1:0] head_wa;
  logic [LW-1:0] head_wd;
  logic [BW-1:0] head_ra;

  // node store ports
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_key, rd_value;
  logic [LW-1:0] rd_link;
  logic          wr_node, wr_link;
  logic [AW-1:0] wr_addr;
  logic [LW-1:0] wr_link_data;

  // second write cycles: predecessor link patch for put and remove
  logic          patch_pend;
  logic [LW-1:0] patch_data;
  logic          alloc_ok;
  logic          put_ok;

  logic [BW-1:0] req_bkt;
  assign req_bkt = BW'(req.key & 32'(BUCKETS - 1));
  assign alloc_ok = (free_head < NIL) || (fresh_index < NIL);

  chme_node_store #(.NODES(NODES), .AW(AW), .LW(LW)) u_store (
    .clk, .rd_en, .rd_addr, .rd_key, .rd_value, .rd_link,
    .wr_node, .wr_link, .wr_addr, .wr_key(key), .wr_value(val), .wr_link_data
  );

  // head read follows the incoming request while idle
  assign head_ra = (state == S_IDLE) ? req_bkt : bkt;

  always_ff @(posedge clk) begin
    if (head_we) heads[head_wa] <= head_wd;
    head_rd <= heads[head_ra];
  end

  assign req_stall = (state != S_IDLE) || rsp_valid;

  // sequencer register
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // next state and memory controls
  always_comb begin
    state_next   = state;
    head_we      = 1'b0;
    head_wa      = bkt;
    head_wd      = NIL;
    rd_en        = 1'b0;
    rd_addr      = cur[AW-1:0];
    wr_node      = 1'b0;
    wr_link      = 1'b0;
    wr_addr      = cur[AW-1:0];
    wr_link_data = NIL;
    case (state)
      S_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_idx[BW-1:0];
        if (clr_idx == (BW+1)'(BUCKETS - 1)) state_next = S_IDLE;
      end
      S_IDLE: if (req_valid && !req_stall) state_next = S_HEAD;
      S_HEAD: state_next = (op == OP_NONE) ? S_DONE : S_READ;
      S_READ: begin
        // cur holds the chain position after head or link read
        if (cur >= NIL) begin
          if (op == OP_PUT) state_next = (free_head < NIL) ? S_FREERD : S_ALLOC;
          else              state_next = S_DONE;
        end else begin
          rd_en = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_key == key) begin
          state_next = (op == OP_REMOVE) ? S_UNLINK : S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_FREERD: begin
        rd_en = 1'b1;
        rd_addr = free_head[AW-1:0];
        state_next = S_FREEWAIT;
      end
      S_FREEWAIT: state_next = S_ALLOC;
      S_ALLOC: begin
        if (alloc_ok) begin
          wr_node = 1'b1;
          wr_addr = (free_head < NIL) ? free_head[AW-1:0] : fresh_index[AW-1:0];
        end
        state_next = S_DONE;
      end
      S_UNLINK: begin
        // hit node points at old free head; predecessor or head skips it
        wr_link = 1'b1;
        wr_addr = cur[AW-1:0];
        wr_link_data = free_head;
        if (pred >= NIL) begin
          head_we = 1'b1;
          head_wd = hit_link;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        // patch of predecessor link or bucket head, in the cycle after alloc or unlink
        if (patch_pend && (pred < NIL)) begin
          wr_link      = 1'b1;
          wr_addr      = pred[AW-1:0];
          wr_link_data = patch_data;
        end else if (patch_pend && (op == OP_PUT)) begin
          head_we = 1'b1;
          head_wd = patch_data;
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx      <= '0;
      free_head    <= NIL;
      fresh_index  <= '0;
      stored_count <= '0;
      rsp_valid    <= 1'b0;
      patch_pend   <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      if (state == S_CLEAR) clr_idx <= clr_idx + 1'b1;
      patch_pend <= 1'b0;
      case (state)
        S_IDLE: if (req_valid && !req_stall) begin
          op   <= op_t'(req.req_type);
          key  <= req.key;
          val  <= req.value;
          bkt  <= req_bkt;
          found <= 1'b0;
        end
        S_HEAD: begin
          cur  <= head_rd;
          pred <= NIL;
        end
        S_CMP: begin
          if (rd_key == key) begin
            found    <= 1'b1;
            hit_val  <= rd_value;
            hit_link <= rd_link;
          end else begin
            pred <= cur;
            cur  <= rd_link;
          end
        end
        S_ALLOC: if (alloc_ok) begin
          stored_count <= stored_count + 1'b1;
          patch_data   <= (free_head < NIL) ? free_head : fresh_index;
          patch_pend   <= 1'b1;
          if (free_head < NIL) free_head <= rd_link;
          else                 fresh_index <= fresh_index + 1'b1;
        end
        S_UNLINK: begin
          free_head <= cur;
          if (stored_count != 0) stored_count <= stored_count - 1'b1;
          patch_data <= hit_link;
          patch_pend <= 1'b1;
        end
        S_DONE: begin
          rsp_valid <= 1'b1;
          rsp.entry_count <= stored_count;
          rsp.value_out   <= '0;
          rsp.status      <= ST_MISS;
          case (op)
            OP_GET: if (found) begin
              rsp.value_out <= hit_val;
              rsp.status    <= ST_OK;
            end
            OP_PUT: rsp.status <= found ? ST_PRESENT : (put_ok ? ST_OK : ST_FULL);
            OP_REMOVE: if (found) begin
              rsp.value_out <= hit_val;
              rsp.status    <= ST_OK;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // remember whether the allocation succeeded
  always_ff @(posedge clk) begin
    if (state == S_HEAD) put_ok <= 1'b0;
    else if (state == S_ALLOC) put_ok <= alloc_ok;
  end

endmodule
`default_nettype wire

[tb/tb_chained_hash_map_engine_top.sv]
// testbench: chained hash map engine driven through its request and result channels
`default_nettype none

// result scoreboard: holds its own copy of the map and the queue of predicted results
class map_scoreboard;
  localparam int NBKT = 64;
  localparam int NPOOL = 256;
  localparam int NULLIX = NPOOL;

  int unsigned heads[NBKT];
  logic [31:0] nkey[NPOOL];
  logic [31:0] nval[NPOOL];
  int unsigned nlink[NPOOL];
  int unsigned free_top;
  int unsigned fresh;
  int unsigned live;
  chme_pkg::rsp_t pending[$];
  int mismatches;

  function new();
    for (int i = 0; i < NBKT; i++) heads[i] = NULLIX;
    for (int i = 0; i < NPOOL; i++) begin
      nkey[i] = '0;
      nval[i] = '0;
      nlink[i] = 0;
    end
    free_top = NULLIX;
    fresh = 0;
    live = 0;
    mismatches = 0;
  endfunction

  // walk a chain; returns node or null, pred gets predecessor or tail
  function int unsigned lookup(logic [31:0] k, output int unsigned pred);
    int unsigned cur;
    int unsigned steps;
    cur = heads[k[5:0]];
    pred = NULLIX;
    steps = 0;
    while (cur < NULLIX && steps < NPOOL) begin
      if (nkey[cur] == k) return cur;
      pred = cur;
      cur = nlink[cur];
      steps++;
    end
    return NULLIX;
  endfunction

  // note an accepted request and work out its result
  function void note_request(chme_pkg::req_t r);
    chme_pkg::rsp_t res;
    int unsigned hit;
    int unsigned pred;
    int unsigned n;
    res.value_out = '0;
    res.status = chme_pkg::ST_MISS;
    case (chme_pkg::op_t'(r.req_type))
      chme_pkg::OP_GET: begin
        hit = lookup(r.key, pred);
        if (hit < NULLIX) begin
          res.value_out = nval[hit];
          res.status = chme_pkg::ST_OK;
        end
      end
      chme_pkg::OP_PUT: begin
        hit = lookup(r.key, pred);
        if (hit < NULLIX) res.status = chme_pkg::ST_PRESENT;
        else begin
          n = NULLIX;
          if (free_top < NULLIX) begin
            n = free_top;
            free_top = nlink[n];
          end else if (fresh < NPOOL) begin
            n = fresh;
            fresh++;
          end
          if (n < NULLIX) begin
            nkey[n] = r.key;
            nval[n] = r.value;
            nlink[n] = NULLIX;
            if (pred < NULLIX) nlink[pred] = n;
            else heads[r.key[5:0]] = n;
            live++;
            res.status = chme_pkg::ST_OK;
          end else res.status = chme_pkg::ST_FULL;
        end
      end
      chme_pkg::OP_REMOVE: begin
        hit = lookup(r.key, pred);
        if (hit < NULLIX) begin
          if (pred < NULLIX) nlink[pred] = nlink[hit];
          else heads[r.key[5:0]] = nlink[hit];
          res.value_out = nval[hit];
          nlink[hit] = free_top;
          free_top = hit;
          if (live > 0) live--;
          res.status = chme_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    res.entry_count = live[8:0];
    pending.push_back(res);
  endfunction

  // compare one result with the oldest prediction
  function void check_result(chme_pkg::rsp_t got);
    chme_pkg::rsp_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending.pop_front();
    if (got.value_out !== want.value_out || got.status !== want.status ||
        got.entry_count !== want.entry_count) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: expected value %h status %0d count %0d,",
                  " got value %h status %0d count %0d"},
                 want.value_out, want.status, want.entry_count,
                 got.value_out, got.status, got.entry_count);
    end
  endfunction
endclass

module tb_chained_hash_map_engine_top;
  timeunit 1ns;
  timeprecision 1ps;
  import chme_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  map_scoreboard board;
  logic [31:0] keyset[16];
  bit hold_results;
  int idle_cycles = 0;

  chained_hash_map_engine_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // send one request, with a random gap before it when gaps is set; starts and ends at a falling edge
  task automatic send_request(op_t op, logic [31:0] k, logic [31:0] v, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 14) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req.req_type <= op;
    req.key <= k;
    req.value <= v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_request(req);
    @(negedge clk);
  endtask

  // wait at a falling edge until every predicted result has come
  task automatic drain_results();
    req_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // pick a key: mostly from a small set sharing few buckets so chains grow
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1, 2: return {3'($urandom_range(0, 7)), 27'd0, 2'($urandom_range(0, 3))};
      default: return keyset[$urandom_range(0, 15)];
    endcase
  endfunction

  task automatic random_request();
    int pick;
    op_t op;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = OP_PUT;
    else if (pick < 65) op = OP_GET;
    else if (pick < 97) op = OP_REMOVE;
    else op = OP_NONE;
    send_request(op, pick_key(), $urandom(), 1'b1);
  endtask

  // result side: random stall per result, long hold-off on request
  initial begin
    int wait_cycles;
    rsp_stall = 1'b1;
    @(negedge clk);
    while (1) begin
      if (hold_results) begin
        rsp_stall <= 1'b1;
        repeat (60) @(negedge clk);
        hold_results = 1'b0;
      end else begin
        wait_cycles = $urandom_range(0, 14);
        if (wait_cycles > 0) begin
          rsp_stall <= 1'b1;
          repeat (wait_cycles) @(negedge clk);
        end
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!(rsp_valid && !rsp_stall) && !hold_results) @(posedge clk);
      @(negedge clk);
    end
  end

  // sample results
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) board.check_result(rsp);
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    board = new();
    hold_results = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    for (int i = 0; i < 16; i++)
      keyset[i] = {2'($urandom_range(0, 3)), 24'd0, 2'd0, 4'(i % 4)} ^
                  ((i >= 8) ? 32'hFFFF_FFC0 : 32'h0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, every operation, duplicate put, chain unlink
    send_request(OP_GET, 32'h0, 32'h0, 1'b0);
    send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_request(OP_PUT, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_request(OP_PUT, 32'h0, 32'h1234_5678, 1'b0);
    send_request(OP_PUT, 32'h0000_0040, 32'hAAAA_5555, 1'b0);
    send_request(OP_PUT, 32'h0000_0080, 32'h5555_AAAA, 1'b0);
    send_request(OP_GET, 32'h0000_0080, 32'h0, 1'b0);
    send_request(OP_GET, 32'h0000_00C0, 32'h0, 1'b0);
    send_request(OP_REMOVE, 32'h0000_0040, 32'h0, 1'b0);
    send_request(OP_GET, 32'h0000_0080, 32'h0, 1'b0);
    send_request(OP_REMOVE, 32'h0, 32'h0, 1'b0);
    send_request(OP_PUT, 32'h8000_0000, 32'h8000_0001, 1'b0);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b0);
    send_request(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_request(OP_GET, 32'h8000_0000, 32'h0, 1'b0);

    // random traffic, with a long result hold-off and a drain pause
    for (int i = 0; i < 700; i++) begin
      if (i == 100) hold_results = 1'b1;
      if (i == 300) drain_results();
      random_request();
    end

    // fill the pool past its limit, then more puts and mixed random traffic
    for (int i = 0; i < 270; i++) send_request(OP_PUT, $urandom(), $urandom(), i < 20);
    for (int i = 0; i < 40; i++) send_request(OP_PUT, pick_key(), $urandom(), 1'b1);
    for (int i = 0; i < 100; i++) random_request();

    drain_results();
    repeat (200) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
